@@ hdl/modular_exponentiation_unit_defines.svh @@
// Assertion macros shared by the modular exponentiation unit
`ifndef MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define MEU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, clocked on clk, disabled in reset
`define MEU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

@@ hdl/meu_pkg.sv @@
// Package: widths, constants and control types of the modular exponentiation unit
package meu_pkg;

    localparam int BASE_W        = 32;
    localparam int EXPN_W        = 63;
    localparam int CFG_W         = 31;
    localparam int OUT_W         = 31;
    localparam int EXP_BITS_DEF  = 63;
    localparam int MOD_BITS_DEF  = 31;
    localparam logic [CFG_W-1:0] MODULUS_RESET = 31'd1000000007;

    typedef enum logic [1:0] {
        OP_BASE,
        OP_SQR,
        OP_MUL
    } meu_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_SQR,
        ST_MUL,
        ST_DONE
    } meu_state_t;

    typedef struct packed {
        logic    cfg_wr;
        logic    load;
        logic    mul_start;
        meu_op_t op;
        logic    exp_shift;
        logic    out_load;
    } meu_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic exp_bit;
        logic exp_last;
        logic mod_small;
    } meu_stat_t;

endpackage

@@ hdl/meu_datapath.sv @@
// Datapath: modulus register, exponent shifter and bit-serial modular multiplier
`include "modular_exponentiation_unit_defines.svh"

module meu_datapath #(
    parameter int EXP_BITS = meu_pkg::EXP_BITS_DEF,
    parameter int MOD_BITS = meu_pkg::MOD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  meu_pkg::meu_cmd_t         cmd,
    output meu_pkg::meu_stat_t        stat,
    input  logic [meu_pkg::CFG_W-1:0] modulus,
    input  logic [meu_pkg::BASE_W-1:0] base_value,
    input  logic [meu_pkg::EXPN_W-1:0] exponent,
    output logic [meu_pkg::OUT_W-1:0] power_result
);
    import meu_pkg::*;

    localparam int MW  = (MOD_BITS < CFG_W) ? MOD_BITS : CFG_W;
    localparam int YW  = BASE_W;
    localparam int CW  = $clog2(YW);
    localparam int ECW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

    logic [CFG_W-1:0]    mod_reg;
    logic [MW-1:0]       m;
    logic [EXP_BITS-1:0] exp_reg;
    logic [ECW-1:0]      ecnt_reg;
    logic [MW-1:0]       acc_reg;
    logic [MW-1:0]       base_reg;
    logic [MW-1:0]       x_reg;
    logic [YW-1:0]       y_reg;
    logic [MW-1:0]       p_reg;
    logic [MW-1:0]       p_next;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic                dst_base_reg;
    logic [MW-1:0]       result_reg;
    logic [MW+1:0]       t;
    logic [MW+1:0]       m1;
    logic [MW+1:0]       m2;

    assign m  = mod_reg[MW-1:0];
    assign m1 = {2'b00, m};
    assign m2 = {1'b0, m, 1'b0};

    always_comb
    begin
        t = {1'b0, p_reg, 1'b0} + (y_reg[YW-1] ? {2'b00, x_reg} : '0);
        if (t >= m2)
        begin
            p_next = MW'(t - m2);
        end
        else if (t >= m1)
        begin
            p_next = MW'(t - m1);
        end
        else
        begin
            p_next = t[MW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg  <= MODULUS_RESET;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_wr)
            begin
                mod_reg <= modulus;
            end
            done_reg <= busy_reg && (cnt_reg == '0);
            if (cmd.mul_start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (cnt_reg == '0))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            exp_reg  <= EXP_BITS'(exponent);
            ecnt_reg <= ECW'(EXP_BITS - 1);
            acc_reg  <= MW'(1);
        end
        else if (cmd.exp_shift)
        begin
            exp_reg  <= exp_reg << 1;
            ecnt_reg <= ecnt_reg - 1'b1;
        end

        if (cmd.mul_start)
        begin
            p_reg <= '0;
            case (cmd.op)
                OP_BASE:
                begin
                    x_reg        <= MW'(1);
                    y_reg        <= base_value;
                    cnt_reg      <= CW'(YW - 1);
                    dst_base_reg <= 1'b1;
                end
                OP_MUL:
                begin
                    x_reg        <= acc_reg;
                    y_reg        <= {base_reg, {(YW-MW){1'b0}}};
                    cnt_reg      <= CW'(MW - 1);
                    dst_base_reg <= 1'b0;
                end
                default:
                begin
                    x_reg        <= acc_reg;
                    y_reg        <= {acc_reg, {(YW-MW){1'b0}}};
                    cnt_reg      <= CW'(MW - 1);
                    dst_base_reg <= 1'b0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            p_reg   <= p_next;
            y_reg   <= y_reg << 1;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                if (dst_base_reg)
                begin
                    base_reg <= p_next;
                end
                else
                begin
                    acc_reg <= p_next;
                end
            end
        end

        if (cmd.out_load)
        begin
            result_reg <= stat.mod_small ? '0 : acc_reg;
        end
    end

    assign stat.mul_done  = done_reg;
    assign stat.exp_bit   = exp_reg[EXP_BITS-1];
    assign stat.exp_last  = (ecnt_reg == '0);
    assign stat.mod_small = (m < MW'(2));

    assign power_result = OUT_W'(result_reg);

    `MEU_ASSERT_IMPL(a_part_below_mod, busy_reg && !stat.mod_small, p_reg < m)
    `MEU_ASSERT_IMPL(a_no_restart, cmd.mul_start, !busy_reg)
    `MEU_ASSERT_NEXT(a_done_pulse, busy_reg && (cnt_reg == '0) && !cmd.mul_start,
                     done_reg && !busy_reg)

endmodule

@@ hdl/meu_ctrl.sv @@
// Controller: sequences base reduction, squarings and multiplies per exponent bit
module meu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    output meu_pkg::meu_cmd_t   cmd,
    input  meu_pkg::meu_stat_t  stat
);
    import meu_pkg::*;

    meu_state_t state_reg;
    meu_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.op         = OP_SQR;
        cmd.cfg_wr     = cfg_valid && cfg_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.mod_small)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.op        = OP_BASE;
                        state_next    = ST_BASE;
                    end
                end
            end
            ST_BASE:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (stat.mul_done)
                begin
                    if (stat.exp_bit)
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.op        = OP_MUL;
                        state_next    = ST_MUL;
                    end
                    else if (stat.exp_last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.exp_shift = 1'b1;
                        cmd.mul_start = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                if (stat.mul_done)
                begin
                    if (stat.exp_last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.exp_shift = 1'b1;
                        cmd.mul_start = 1'b1;
                        state_next    = ST_SQR;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !in_valid;
    assign out_valid = out_valid_reg;

endmodule

@@ hdl/modular_exponentiation_unit.sv @@
// From accept to result valid the unit reduces the base, then for each of the EXP_BITS exponent
// bits squares and, for a set bit, multiplies; MW = MOD_BITS capped at 31. A modulus below 2
// gives 0 without these steps. The bit-serial multiplier takes one multiplier bit per cycle,
// over the 32-bit base for the base reduction and the MW-bit operand for a square or multiply.
// One item at a time: the next is accepted once the result sits in the output register.
// Reset (rst_n, async, active low) sets the modulus to 1000000007 and empties the output.
module modular_exponentiation_unit #(
    parameter int EXP_BITS = meu_pkg::EXP_BITS_DEF,
    parameter int MOD_BITS = meu_pkg::MOD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [meu_pkg::BASE_W-1:0] base_value,
    input  logic [meu_pkg::EXPN_W-1:0] exponent,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [meu_pkg::OUT_W-1:0]  power_result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [meu_pkg::CFG_W-1:0]  modulus
);
    import meu_pkg::*;

    meu_cmd_t  cmd;
    meu_stat_t stat;

    meu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    meu_datapath #(
        .EXP_BITS (EXP_BITS),
        .MOD_BITS (MOD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .modulus      (modulus),
        .base_value   (base_value),
        .exponent     (exponent),
        .power_result (power_result)
    );

endmodule
